@@ design/selsort_pkg.sv @@
// Shared types and sizing constants for the selection sorter.
// No dependencies; the store, compare unit and top level import this package.
`default_nettype none

package selsort_pkg;

	// Store depth and derived widths
	localparam int unsigned DEPTH  = 64;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Control beat that travels alongside a store read into the compare unit
	typedef struct packed {
		logic  vld;    // read data in this cycle belongs to the scan
		logic  first;  // read is the head position of the current pass
		addr_t idx;    // store address the data came from
	} cmp_ctl_t;

endpackage

`default_nettype wire

@@ design/selsort_store.sv @@
// Element store of the selection sorter: one write port, one read port
// with registered read data. Depends on selsort_pkg.
`default_nettype none

module selsort_store
	import selsort_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  wr_en,
	input  wire addr_t wr_addr,
	input  wire data_t wr_data,
	input  wire addr_t rd_addr,
	output data_t      rd_data_q
);

	data_t mem_q [DEPTH];

	// Write one entry per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one entry per cycle, data registered
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

@@ design/selsort_cmp.sv @@
// Shared compare unit: tracks the first minimum of a scan pass and keeps
// the value found at the head position for the swap. Depends on selsort_pkg.
`default_nettype none

module selsort_cmp
	import selsort_pkg::*;
(
	input  wire logic     clk,
	input  wire cmp_ctl_t ctl_s1,
	input  wire data_t    rd_data,
	output data_t        best_val_q,
	output addr_t        best_idx_q,
	output data_t        head_val_q
);

	logic take;

	// Strictly smaller only, so the first minimum wins
	assign take = ctl_s1.first || ($signed(rd_data) < $signed(best_val_q));

	// Update the running minimum on every scan beat
	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			if (take) begin
				best_val_q <= rd_data;
				best_idx_q <= ctl_s1.idx;
			end
			if (ctl_s1.first) begin
				head_val_q <= rd_data;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/selection_sorter.sv @@
// Top level of the selection sorter: load, sort and emit sequencer.
// Depends on selsort_pkg, selsort_store and selsort_cmp.
//
// Usage:
//   Slave stream: one signed 32-bit element per beat; tlast closes the set.
//   Elements beyond 64 per set are dropped; tuser on every result beat of
//   that set is then 1.
//   Master stream: the set in ascending order, one element per beat, tlast
//   on the final one. Equal elements keep selection-sort order.
//   Loading keeps tready high. After the closing beat tready stays low
//   while the set is sorted and emitted: for a set of n elements, each
//   position p of 0..n-2 takes a scan from p to the last element, a
//   drain state and two swap writes, all through the single store read
//   port feeding the one shared comparator. Each result beat passes
//   through EMIT and EMIT_LD. The next set may start loading as soon as
//   the final result sits in the output register.
//   A receiver stall holds the output register and pauses emission; no
//   beat is lost. Reset (arst_n low) empties the set and the output
//   register; no store clearing pass is needed.
`default_nettype none

module selection_sorter
	import selsort_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] value
	input  wire logic        s_axis_tlast,   // last
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] sorted_value
	output logic             m_axis_tlast,   // last_out
	output logic             m_axis_tuser    // [0] overflowed
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_EMIT,
		ST_EMIT_LD
	} state_t;

	state_t   state_q;
	cnt_t     count_q;
	logic     ovf_q;
	addr_t    pos_q;
	addr_t    scan_q;
	addr_t    emit_q;
	cmp_ctl_t ctl_s1;
	logic     out_vld_q;
	data_t    out_data_q;
	logic     out_last_q;
	logic     out_ovf_q;

	logic     in_beat;
	logic     full;
	cnt_t     count_nx;
	cnt_t     cnt_m1;
	addr_t    last_idx;
	logic     pass_done;
	logic     out_free;
	logic     wr_en;
	addr_t    wr_addr;
	data_t    wr_data;
	addr_t    rd_addr;
	data_t    rd_data;
	data_t    best_val;
	addr_t    best_idx;
	data_t    head_val;

	// Handshake and count helpers
	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign full          = (count_q == CNT_W'(DEPTH));
	assign count_nx      = full ? count_q : count_q + CNT_W'(1);
	assign cnt_m1        = count_q - CNT_W'(1);
	assign last_idx      = cnt_m1[ADDR_W-1:0];
	assign pass_done     = (CNT_W'(pos_q) + CNT_W'(2)) >= count_q;
	assign out_free      = !out_vld_q || m_axis_tready;

	// Store write port: loading beats and the two halves of a swap
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = best_val;
		case (state_q)
			ST_LOAD: begin
				wr_en   = in_beat && !full;
				wr_addr = count_q[ADDR_W-1:0];
				wr_data = s_axis_tdata;
			end
			ST_SWAP_A: begin
				wr_en   = 1'b1;
				wr_addr = best_idx;
				wr_data = head_val;
			end
			ST_SWAP_B: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = best_val;
			end
			default: begin
				wr_en   = 1'b0;
			end
		endcase
	end

	// Store read port: scan address while sorting, else emit address
	assign rd_addr = (state_q == ST_SCAN) ? scan_q : emit_q;

	selsort_store u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data)
	);

	selsort_cmp u_cmp (
		.clk        (clk),
		.ctl_s1     (ctl_s1),
		.rd_data    (rd_data),
		.best_val_q (best_val),
		.best_idx_q (best_idx),
		.head_val_q (head_val)
	);

	// Sequencer: load, scan passes with swaps, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			pos_q     <= '0;
			scan_q    <= '0;
			emit_q    <= '0;
			ctl_s1    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			ctl_s1.vld <= (state_q == ST_SCAN);
			if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_beat) begin
						count_q <= count_nx;
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							pos_q  <= '0;
							scan_q <= '0;
							emit_q <= '0;
							if (count_nx >= CNT_W'(2)) begin
								state_q <= ST_SCAN;
							end else begin
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_SCAN: begin
					ctl_s1.first <= (scan_q == pos_q);
					ctl_s1.idx   <= scan_q;
					if (scan_q == last_idx) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_q <= scan_q + ADDR_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_SWAP_A;
				end
				ST_SWAP_A: begin
					state_q <= ST_SWAP_B;
				end
				ST_SWAP_B: begin
					if (pass_done) begin
						state_q <= ST_EMIT;
					end else begin
						pos_q   <= pos_q + ADDR_W'(1);
						scan_q  <= pos_q + ADDR_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_EMIT_LD;
					end
				end
				ST_EMIT_LD: begin
					out_vld_q  <= 1'b1;
					out_data_q <= rd_data;
					out_last_q <= (emit_q == last_idx);
					out_ovf_q  <= ovf_q;
					if (emit_q == last_idx) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end else begin
						emit_q  <= emit_q + ADDR_W'(1);
						state_q <= ST_EMIT;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_ovf_q;

endmodule

`default_nettype wire

@@ design/selsort_checker.sv @@
// Port-level checker for the selection sorter, bound to the top level.
// Depends on selection_sorter's ports only.
`default_nettype none

module selsort_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        s_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic        m_axis_tuser
);

	logic        out_beat;
	logic        have_prev_q;
	logic [31:0] prev_q;
	logic        prev_ovf_q;

	assign out_beat = m_axis_tvalid && m_axis_tready;

	// Track the previous result beat of the current set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			prev_ovf_q  <= 1'b0;
		end else if (out_beat) begin
			have_prev_q <= !m_axis_tlast;
			prev_q      <= m_axis_tdata;
			prev_ovf_q  <= m_axis_tuser;
		end
	end

	// A stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat withdrawn while stalled");

	// Results of one set come out in ascending order
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && have_prev_q |-> $signed(m_axis_tdata) >= $signed(prev_q))
		else $error("result beats out of order");

	// The overflow flag is the same on every beat of a set
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && have_prev_q |-> m_axis_tuser == prev_ovf_q)
		else $error("overflow flag changed within a set");

	// The closing input beat stops further input while the set is processed
	a_close_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken straight after closing beat");

endmodule

bind selection_sorter selsort_checker u_selsort_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for selection_sorter: streams signed sets in, checks sorted beats out.
// Depends on selsort_pkg and the selection_sorter RTL; a small scoreboard class predicts results.
`default_nettype none

module tb_top;
	import selsort_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned ITEM_TARGET = 330;
	localparam int unsigned RX_STALL_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 64;

	// One expected beat on the master side
	typedef struct {
		data_t value;
		logic  last;
		logic  ovf;
	} sorted_beat_t;

	// Collect each set, sort it on the closing beat, hold the sorted beats in order
	class sort_scoreboard;
		logic signed [DATA_W-1:0] set_q[$];
		logic                     set_ovf;
		sorted_beat_t             expected_q[$];
		int                       errors;

		function new();
			set_ovf = 1'b0;
			errors  = 0;
		endfunction

		function void note_element(data_t v, logic l);
			int                       best;
			logic signed [DATA_W-1:0] tmp;
			sorted_beat_t             beat;
			// store, or drop once the set holds DEPTH elements
			if (set_q.size() < DEPTH) begin
				set_q.push_back(v);
			end else begin
				set_ovf = 1'b1;
			end
			if (!l) return;
			// selection sort: first minimum of the remainder goes into place
			for (int p = 0; p + 1 < set_q.size(); p++) begin
				best = p;
				for (int s = p + 1; s < set_q.size(); s++) begin
					if (set_q[s] < set_q[best]) best = s;
				end
				tmp         = set_q[p];
				set_q[p]    = set_q[best];
				set_q[best] = tmp;
			end
			for (int k = 0; k < set_q.size(); k++) begin
				beat.value = set_q[k];
				beat.last  = (k == set_q.size() - 1);
				beat.ovf   = set_ovf;
				expected_q.push_back(beat);
			end
			set_q.delete();
			set_ovf = 1'b0;
		endfunction

		function void check_beat(data_t v, logic l, logic u);
			sorted_beat_t beat;
			if (expected_q.size() == 0) begin
				$error("unexpected result beat: sorted_value %0d", $signed(v));
				errors++;
				return;
			end
			beat = expected_q.pop_front();
			if (v !== beat.value) begin
				$error("sorted_value: expected %0d, got %0d", $signed(beat.value), $signed(v));
				errors++;
			end
			if (l !== beat.last) begin
				$error("last_out: expected %0b, got %0b", beat.last, l);
				errors++;
			end
			if (u !== beat.ovf) begin
				$error("overflowed: expected %0b, got %0b", beat.ovf, u);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] value
	logic        s_axis_tlast;   // last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;   // [31:0] sorted_value
	logic        m_axis_tlast;   // last_out
	logic        m_axis_tuser;   // [0] overflowed

	sort_scoreboard sb = new();

	int          tx_idle_pct;
	int          rx_idle_pct;
	logic        rx_stalled = 1'b0;
	int unsigned cycle_count = 0;
	int          items_sent;
	event        rx_stall_go;

	selection_sorter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Clock: 12 time units
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: check each accepted beat, then pick next tready
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		end
		m_axis_tready <= !rx_stalled && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Hold the receiver off for a long stretch on request
	initial begin
		forever begin
			@(rx_stall_go);
			@(posedge clk);
			rx_stalled <= 1'b1;
			repeat (RX_STALL_CYCLES) @(posedge clk);
			rx_stalled <= 1'b0;
		end
	end

	// Offer one beat, with random gaps ahead of it
	task automatic send_item(input data_t v, input logic l);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tlast  <= l;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_element(v, l);
		items_sent++;
	endtask

	task automatic send_set(input data_t vals[$]);
		foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
	endtask

	// Mix of full-range, extreme, small and heavily repeated values
	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			5, 6: return $urandom_range(0, 16) - 8;
			default: return $urandom_range(0, 3) * 1000 - 1500;
		endcase
	endfunction

	// Mostly short sets; a full store, an overflow by one and a few near the depth
	function automatic int pick_size(int set_no);
		int r;
		r = $urandom_range(0, 99);
		if (set_no == 3) return DEPTH;
		if (set_no == 9) return DEPTH + 1;
		if (set_no == 17) return $urandom_range(DEPTH + 2, DEPTH + 8);
		if (r < 3) return $urandom_range(DEPTH - 4, DEPTH + 6);
		if (r < 15) return $urandom_range(9, 20);
		return $urandom_range(1, 8);
	endfunction

	// Stimulus
	initial begin
		data_t set_buf[$];
		int    set_no;
		int    n;
		int    phase;

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		rx_idle_pct   <= 57;
		tx_idle_pct   = 33;
		items_sent    = 0;
		set_no        = 0;
		phase         = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-element sets at the extremes and zero
		send_item(32'h7FFF_FFFF, 1'b1);
		send_item(32'h8000_0000, 1'b1);
		send_item(32'h0000_0000, 1'b1);
		// extremes, duplicates and alternating bit patterns
		set_buf = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
		send_set(set_buf);
		// already ascending
		set_buf = '{32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0, 32'h1};
		send_set(set_buf);
		// descending with a tie
		set_buf = '{32'd100, 32'd50, 32'd50, -32'sd50};
		send_set(set_buf);

		// random sets, idling swapped partway, then none with a long receiver stall
		while (items_sent < ITEM_TARGET) begin
			if (phase == 0 && items_sent >= 120) begin
				phase = 1;
				tx_idle_pct = 57;
				rx_idle_pct <= 33;
			end else if (phase == 1 && items_sent >= 225) begin
				phase = 2;
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
				-> rx_stall_go;
				// keep offering while the receiver is held: the block must back up
				repeat (2) begin
					set_buf.delete();
					repeat (12) set_buf.push_back(pick_value());
					send_set(set_buf);
				end
			end
			n = pick_size(set_no);
			set_buf.delete();
			repeat (n) set_buf.push_back(pick_value());
			send_set(set_buf);
			set_no++;
		end
		s_axis_tvalid <= 1'b0;

		// drain, then allow for stray beats
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
